>>> sv/arpc_pkg.sv
// Package: shared types and constants of the ARP cache.
`default_nettype none
package arpc_pkg;
  localparam int unsigned CacheEntries = 16;
  localparam int unsigned IdxW = $clog2(CacheEntries);
  localparam int unsigned CntW = $clog2(CacheEntries + 1);

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LK_IP  = 3'd1,
    OP_LK_MAC = 3'd2,
    OP_INSERT = 3'd3,
    OP_PACKET = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_ANSWER  = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_REPLY   = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  localparam logic [1:0] CfgLocalIp = 2'd0;
  localparam logic [1:0] CfgBcastIp = 2'd1;
  localparam logic [1:0] CfgTtlMax  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EMIT2,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  ttl;
    logic [7:0]  reload;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        found;
    logic [3:0]  entry_index;
    logic [31:0] ip_out;
    logic [47:0] mac_out;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [7:0]  ttl_value;
    logic        want_request;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_opcode;
    logic [31:0] target_ip;
  } item_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic       shift;
    logic       age;
    logic       write;
    logic       refresh;
    logic [7:0] ttl;
    logic [31:0] ip;
    logic [47:0] mac;
  } cell_ctl_t;
endpackage
`default_nettype wire

>>> sv/arpc_if.sv
// Interfaces: valid/ready channels for items and results.
`default_nettype none
interface arpc_in_if;
  logic valid;
  logic ready;
  arpc_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface arpc_out_if;
  logic valid;
  logic ready;
  arpc_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/arpc_cell.sv
// Cell: one table slot in the rotating ring of entries.
`default_nettype none
module arpc_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire arpc_pkg::cell_ctl_t ctl_i,
  input  wire logic [31:0]         bcast_ip_i,
  input  wire arpc_pkg::entry_t    prev_i,
  output arpc_pkg::entry_t         ent_o
);
  import arpc_pkg::*;
  logic valid_q, valid_d;
  logic [31:0] ip_q, ip_d;
  logic [47:0] mac_q, mac_d;
  logic [7:0] ttl_q, ttl_d, reload_q, reload_d;
  logic [7:0] dec;

  // Head cell ops apply to prev_i (the entry arriving in this cycle).
  assign dec = prev_i.ttl - 8'd1;

  always_comb begin
    valid_d = valid_q; ip_d = ip_q; mac_d = mac_q;
    ttl_d = ttl_q; reload_d = reload_q;
    if (ctl_i.shift) begin
      valid_d = prev_i.valid; ip_d = prev_i.ip; mac_d = prev_i.mac;
      ttl_d = prev_i.ttl; reload_d = prev_i.reload;
      if (ctl_i.age && prev_i.valid) begin
        ttl_d = dec;
        if (dec == 8'd0) valid_d = 1'b0;
        if (prev_i.ip == bcast_ip_i) ttl_d = prev_i.reload;
      end
      if (ctl_i.refresh) ttl_d = prev_i.reload;
      if (ctl_i.write) begin
        valid_d = 1'b1; ip_d = ctl_i.ip; mac_d = ctl_i.mac;
        ttl_d = ctl_i.ttl; reload_d = ctl_i.ttl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ip_q <= ip_d; mac_q <= mac_d; ttl_q <= ttl_d; reload_q <= reload_d;
  end

  assign ent_o = '{valid: valid_q, ip: ip_q, mac: mac_q, ttl: ttl_q, reload: reload_q};
endmodule
`default_nettype wire

>>> sv/arp_cache_with_aging.sv
// Top level: ARP cache with aging built as a rotating ring of cells.
// Usage:
//   in_if carries one item per handshake (tick, lookup by IP or MAC, insert,
//   ARP packet); out_if returns the result items of that item, the final one
//   marked by last. The user writes registers via cfg_we_i/cfg_idx_i/
//   cfg_data_i only while the block is idle; the block does not enforce it.
// Operation:
//   Every item rotates the 16-slot ring once; an insert with no IP hit but a
//   free slot rotates it twice. One slot passes the head cell per cycle unless
//   a tick request finds the output full. One item is at work at a time.
//   During the walk a tick ages each passing slot and hands out refresh
//   requests as they arise; lookups remember the first hit; insert refreshes
//   the first IP hit or else fills the first free slot on a second walk.
// Reset:
//   All slots are invalid, registers take their reset values.
// Stall:
//   A result waits in the output register; the ring halts while a new result
//   is due and the register is full, so nothing is lost under backpressure.
`default_nettype none
module arp_cache_with_aging (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  arpc_in_if.sink          in_if,
  arpc_out_if.source       out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import arpc_pkg::*;

  logic [31:0] local_ip_q, bcast_ip_q;
  logic [7:0]  ttl_max_q;
  state_e state_q, state_d;
  item_t item_q;
  logic [CntW-1:0] cnt_q, cnt_d;       // slots walked
  logic [IdxW-1:0] pos_q, pos_d;       // index of slot at head
  logic pass_q, pass_d;                // 0 search walk, 1 write walk
  logic hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [31:0] hit_ip_q, hit_ip_d;
  logic [47:0] hit_mac_q, hit_mac_d;
  logic free_q, free_d;                // free slot seen on search walk
  logic done_w_q, done_w_d;            // insert write performed
  result_t res_q, res_d;
  logic res_v_q, res_v_d;
  cell_ctl_t ctl, ctl_fwd;
  entry_t ring [CacheEntries];
  entry_t head;
  logic out_free, walking;
  logic pkt_ok, do_ins;
  logic [31:0] ins_ip;
  logic [47:0] ins_mac;
  logic [7:0]  ins_ttl, half, dec;

  assign head = ring[CacheEntries-1];
  assign out_free = !res_v_q || out_if.ready;
  assign half = {1'b0, ttl_max_q[7:1]};
  assign dec = head.ttl - 8'd1;
  assign pkt_ok = item_q.hw_type == 16'd1 && item_q.proto_type == 16'h0800
                  && item_q.hw_len == 8'd6 && item_q.proto_len == 8'd4
                  && (item_q.arp_opcode == 16'd1 || item_q.arp_opcode == 16'd2);
  assign do_ins = item_q.op == OP_INSERT || (item_q.op == OP_PACKET && pkt_ok);
  assign ins_ip = item_q.ip_addr;
  assign ins_mac = item_q.mac_addr;
  assign ins_ttl = item_q.op == OP_INSERT ? item_q.ttl_value : ttl_max_q;

  // Walk step stalls when a tick request must be emitted but output is full.
  logic tick_req;
  assign tick_req = item_q.op == OP_TICK && head.valid && dec <= half;
  assign walking = state_q == ST_SCAN && (!tick_req || out_free);

  // Cell 0 takes the head slot and applies the operation; the others only rotate.
  for (genvar g = 0; g < CacheEntries; g++) begin : g_cell
    if (g == 0) begin : g_head
      arpc_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl), .bcast_ip_i(bcast_ip_q),
        .prev_i(ring[CacheEntries-1]),
        .ent_o(ring[g])
      );
    end else begin : g_body
      arpc_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl_fwd), .bcast_ip_i(bcast_ip_q),
        .prev_i(ring[g-1]),
        .ent_o(ring[g])
      );
    end
  end

  always_comb begin
    ctl = '0;
    ctl.ip = ins_ip; ctl.mac = ins_mac; ctl.ttl = ins_ttl;
    ctl.shift = walking;
    ctl.age = item_q.op == OP_TICK;
    if (do_ins && !pass_q && head.valid && head.ip == ins_ip && !hit_q) ctl.refresh = 1'b1;
    if (do_ins && pass_q && !head.valid && !done_w_q) ctl.write = 1'b1;
  end

  always_comb begin
    ctl_fwd = '0;
    ctl_fwd.shift = walking;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_if.valid) state_d = ST_SCAN;
      ST_SCAN: begin
        if (walking && cnt_q == CntW'(CacheEntries - 1)) begin
          if (do_ins && !pass_q && !hit_q && !(head.valid && head.ip == ins_ip)
              && (free_q || !head.valid))
            state_d = ST_SCAN;
          else if (item_q.op == OP_LK_IP || item_q.op == OP_LK_MAC) state_d = ST_EMIT;
          else if (item_q.op == OP_PACKET && pkt_ok && item_q.arp_opcode == 16'd1
                   && item_q.target_ip == local_ip_q) state_d = ST_EMIT;
          else state_d = ST_DONE;
        end
      end
      ST_EMIT: if (out_free) begin
        if (item_q.op == OP_LK_IP && !hit_q && item_q.want_request) state_d = ST_EMIT2;
        else if (item_q.op == OP_PACKET) state_d = ST_DONE;
        else state_d = ST_IDLE;
      end
      ST_EMIT2: if (out_free) state_d = ST_IDLE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Walk bookkeeping and results.
  always_comb begin
    cnt_d = cnt_q; pos_d = pos_q; pass_d = pass_q; hit_d = hit_q;
    hit_idx_d = hit_idx_q; hit_ip_d = hit_ip_q; hit_mac_d = hit_mac_q;
    free_d = free_q; done_w_d = done_w_q;
    res_d = res_q; res_v_d = res_v_q && !out_if.ready;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0; pos_d = '0; pass_d = 1'b0; hit_d = 1'b0; free_d = 1'b0;
        done_w_d = 1'b0; hit_idx_d = '0; hit_ip_d = '0; hit_mac_d = '0;
      end
      ST_SCAN: if (walking) begin
        cnt_d = cnt_q + CntW'(1);
        pos_d = pos_q + IdxW'(1);
        if (!head.valid) free_d = 1'b1;
        if (ctl.write) done_w_d = 1'b1;
        if (!hit_q && head.valid && !pass_q &&
            ((item_q.op == OP_LK_MAC && head.mac == item_q.mac_addr) ||
             (item_q.op != OP_LK_MAC && head.ip == item_q.ip_addr))) begin
          hit_d = 1'b1; hit_idx_d = pos_q; hit_ip_d = head.ip; hit_mac_d = head.mac;
        end
        if (tick_req) begin
          res_v_d = 1'b1;
          res_d = '{kind: KIND_REQUEST, found: 1'b0, entry_index: 4'(pos_q),
                    ip_out: head.ip, mac_out: '0, last: 1'b0};
        end
        if (cnt_q == CntW'(CacheEntries - 1) && state_d == ST_SCAN) begin
          cnt_d = '0; pos_d = '0; pass_d = 1'b1;
        end
      end
      ST_EMIT: if (out_free) begin
        res_v_d = 1'b1;
        if (item_q.op == OP_PACKET)
          res_d = '{kind: KIND_REPLY, found: 1'b0, entry_index: '0,
                    ip_out: item_q.ip_addr, mac_out: item_q.mac_addr, last: 1'b0};
        else if (hit_q)
          res_d = '{kind: KIND_ANSWER, found: 1'b1, entry_index: 4'(hit_idx_q),
                    ip_out: hit_ip_q, mac_out: hit_mac_q, last: 1'b1};
        else
          res_d = '{kind: KIND_ANSWER, found: 1'b0, entry_index: '0,
                    ip_out: item_q.op == OP_LK_IP ? item_q.ip_addr : '0, mac_out: '0,
                    last: !(item_q.op == OP_LK_IP && item_q.want_request)};
      end
      ST_EMIT2: if (out_free) begin
        res_v_d = 1'b1;
        res_d = '{kind: KIND_REQUEST, found: 1'b0, entry_index: '0,
                  ip_out: item_q.ip_addr, mac_out: '0, last: 1'b1};
      end
      ST_DONE: if (out_free) begin
        res_v_d = 1'b1;
        res_d = '{kind: KIND_DONE, found: 1'b0, entry_index: '0,
                  ip_out: '0, mac_out: '0, last: 1'b1};
      end
      default: ;
    endcase
  end

  // Items with unknown ops skip straight to done through the walk.
  assign in_if.ready = state_q == ST_IDLE;
  assign out_if.valid = res_v_q;
  assign out_if.data = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; res_v_q <= 1'b0; cnt_q <= '0; pos_q <= '0;
      pass_q <= 1'b0; hit_q <= 1'b0; free_q <= 1'b0; done_w_q <= 1'b0;
      local_ip_q <= '0; bcast_ip_q <= '1; ttl_max_q <= 8'd255;
    end else begin
      state_q <= state_d; res_v_q <= res_v_d; cnt_q <= cnt_d; pos_q <= pos_d;
      pass_q <= pass_d; hit_q <= hit_d; free_q <= free_d; done_w_q <= done_w_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLocalIp: local_ip_q <= cfg_data_i;
          CfgBcastIp: bcast_ip_q <= cfg_data_i;
          CfgTtlMax:  ttl_max_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    hit_idx_q <= hit_idx_d; hit_ip_q <= hit_ip_d; hit_mac_q <= hit_mac_d;
    if (in_if.valid && in_if.ready) item_q <= in_if.data;
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_if.ready) else $error("accept while busy");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped under stall");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> cnt_q < CntW'(CacheEntries)) else $error("walk overrun");
endmodule
`default_nettype wire
